/* sv/anlt_pkg.sv */
// Shared types and constants for the active note list tracker.
`timescale 1ns / 1ps
`default_nettype none
package anlt_pkg;

  localparam int MAX_NOTES_DEF = 64;

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] channel;
    logic [6:0] note;
  } in_t;

  typedef struct packed {
    logic [6:0] held_note;
    logic [3:0] held_channel;
    logic [5:0] position;
    logic [6:0] list_length;
    logic       last;
  } out_t;

  // One list entry as kept in the list RAM.
  typedef struct packed {
    logic [6:0] note;
    logic [3:0] channel;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* sv/anlt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none
module anlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/active_note_list_tracker_unit.sv */
// Top level: ordered list of held notes, kept in one RAM, searched, compacted and sent out.
//
// Usage:
//   Input channel: present a decoded message on in_data and raise start; the message
//   is taken at a clock edge where start is high and busy is low. busy stays high
//   while the message is processed.
//   Result channel: each list entry appears on out_data for exactly one cycle with
//   out_valid high; out_data.last marks the final entry of a run. The receiver cannot
//   stall, so results stream one per cycle once sending starts.
//   A note-on for a new note appends it; a note-off for a held note removes it and
//   the later entries move down. After a change that leaves the list non-empty, the
//   whole list is sent, in order. Ignored messages are taken without raising busy.
// List passes:
//   The list lives in a single RAM with one read and one write per cycle, and every
//   pass (search, move-down, send) walks it one entry per cycle. On the send pass each
//   entry goes through the registered RAM read and then through the output register.
// Reset:
//   rst_n low at a clock edge empties the list and drops any run in progress. The RAM
//   needs no clearing, since only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module active_note_list_tracker_unit #(
  parameter int MAX_NOTES = anlt_pkg::MAX_NOTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire anlt_pkg::in_t in_data,
  output logic               out_valid,
  output anlt_pkg::out_t     out_data
);

  localparam int IW = $clog2(MAX_NOTES);
  localparam int CW = $clog2(MAX_NOTES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [IW-1:0]  prev_r, prev_nxt;
  logic           pend_r, pend_nxt;
  anlt_pkg::in_t  req_r, req_nxt;
  logic           out_valid_r, out_valid_nxt;
  anlt_pkg::out_t out_data_r, out_data_nxt;

  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr;
  logic [anlt_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [anlt_pkg::ENTRY_W-1:0]    ram_rdata;
  anlt_pkg::entry_t                rd_entry;
  anlt_pkg::entry_t                new_entry;
  logic                            rd_go;

  anlt_ram #(
    .WIDTH (anlt_pkg::ENTRY_W),
    .DEPTH (MAX_NOTES)
  ) u_list_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (idx_r[IW-1:0]),
    .rdata_r (ram_rdata)
  );

  assign rd_entry          = anlt_pkg::entry_t'(ram_rdata);
  assign new_entry.note    = req_r.note;
  assign new_entry.channel = req_r.channel;
  assign rd_go             = (idx_r < count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    pend_nxt      = 1'b0;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = prev_r;
    ram_wdata     = ram_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          idx_nxt = '0;
          if (in_data.action == anlt_pkg::ACT_NOTE_ON ||
              in_data.action == anlt_pkg::ACT_NOTE_OFF) begin
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        priority if (pend_r && rd_entry.note == req_r.note) begin
          if (req_r.action == anlt_pkg::ACT_NOTE_ON) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SHIFT;
            idx_nxt   = CW'(prev_r) + CW'(1);
          end
        end else if (rd_go) begin
          idx_nxt  = idx_r + CW'(1);
          prev_nxt = idx_r[IW-1:0];
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          // Not held: append on note-on if there is room.
          if (req_r.action == anlt_pkg::ACT_NOTE_OFF || count_r == CW'(MAX_NOTES)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = count_r[IW-1:0];
            ram_wdata = new_entry;
            count_nxt = count_r + CW'(1);
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end else begin
          // last entry missed: decide on the next cycle
        end
      end

      ST_SHIFT: begin
        // Move each later entry down one place.
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = prev_r - IW'(1);
        end
        if (rd_go) begin
          idx_nxt  = idx_r + CW'(1);
          prev_nxt = idx_r[IW-1:0];
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          count_nxt = count_r - CW'(1);
          idx_nxt   = '0;
          state_nxt = (count_r == CW'(1)) ? ST_IDLE : ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (pend_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.held_note    = rd_entry.note;
          out_data_nxt.held_channel = rd_entry.channel;
          out_data_nxt.position     = 6'(prev_r);
          out_data_nxt.list_length  = 7'(count_r);
          out_data_nxt.last         = ((CW'(prev_r) + CW'(1)) == count_r);
        end
        if (rd_go) begin
          idx_nxt  = idx_r + CW'(1);
          prev_nxt = idx_r[IW-1:0];
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* dv/note_list_checker.sv */
// Checker for the note list tracker: predicts each list run and compares it entry by entry.
`timescale 1ns / 1ps
module note_list_checker
  import anlt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   mismatch_count,
  output int   entries_due
);

  logic [6:0] held_notes [MAX_NOTES_DEF];
  logic [3:0] held_chans [MAX_NOTES_DEF];
  int         held_count = 0;
  out_t       expected_entries [$];
  int         mismatches = 0;
  int         due = 0;

  assign mismatch_count = mismatches;
  assign entries_due    = due;

  task automatic report_mismatch(input string what);
    mismatches++;
    // cap the log; the count still covers every mismatch
    if (mismatches <= 100) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Queue the whole current list as one run of entries.
  function automatic void queue_list_run();
    out_t entry;
    for (int i = 0; i < held_count; i++) begin
      entry.held_note    = held_notes[i];
      entry.held_channel = held_chans[i];
      entry.position     = 6'(i);
      entry.list_length  = 7'(held_count);
      entry.last         = (i == held_count - 1);
      expected_entries.insert(expected_entries.size(), entry);
    end
  endfunction

  function automatic void apply_message(in_t msg);
    int idx;
    idx = 0;
    // match on note number only; the channel is never compared
    while (idx < held_count && held_notes[idx] != msg.note) idx++;
    case (msg.action)
      ACT_NOTE_ON: begin
        if (idx == held_count && held_count < MAX_NOTES_DEF) begin
          held_notes[held_count] = msg.note;
          held_chans[held_count] = msg.channel;
          held_count++;
          queue_list_run();
        end
      end
      ACT_NOTE_OFF: begin
        if (idx < held_count) begin
          for (int i = idx; i < held_count - 1; i++) begin
            held_notes[i] = held_notes[i + 1];
            held_chans[i] = held_chans[i + 1];
          end
          held_count--;
          if (held_count > 0) queue_list_run();
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_entries.delete();
    end else begin
      // retire results before taking a new message in the same edge
      if (out_valid) begin
        if (expected_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected entry note %0d position %0d",
                                    out_data.held_note, out_data.position));
        end else begin
          want = expected_entries.pop_front();
          check_field("held_note", out_data.held_note, want.held_note);
          check_field("held_channel", out_data.held_channel, want.held_channel);
          check_field("position", out_data.position, want.position);
          check_field("list_length", out_data.list_length, want.list_length);
          check_field("last", out_data.last, want.last);
        end
      end
      if (start && !busy) apply_message(in_data);
    end
    due <= expected_entries.size();
  end

endmodule

/* dv/tb_active_note_list_tracker_unit.sv */
// Testbench top for the note list tracker: drives messages and reports the verdict.
`timescale 1ns / 1ps
module tb_active_note_list_tracker_unit;
  import anlt_pkg::*;

  localparam logic [1:0] ACT_OTHER  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   mismatch_count;
  int   entries_due;

  int         gap_pct;
  logic [6:0] live_notes [$];

  active_note_list_tracker_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  note_list_checker list_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .entries_due   (entries_due)
  );

  always #4 clk = ~clk;

  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int live_index(input logic [6:0] note);
    for (int i = 0; i < live_notes.size(); i++) begin
      if (live_notes[i] == note) return i;
    end
    return -1;
  endfunction

  function automatic logic [6:0] free_note();
    logic [6:0] note;
    note = 7'($urandom);
    while (live_index(note) >= 0) note = 7'($urandom);
    return note;
  endfunction

  // Hold start until the transfer, track the held notes for stimulus shaping,
  // then maybe idle for a while.
  task automatic send_msg(input logic [1:0] action, input logic [3:0] channel,
                          input logic [6:0] note);
    in_t msg;
    int  idx;
    msg.action  = action;
    msg.channel = channel;
    msg.note    = note;
    start   <= 1'b1;
    in_data <= msg;
    @(posedge clk);
    while (busy) @(posedge clk);
    idx = live_index(note);
    if (action == ACT_NOTE_ON && idx < 0 && live_notes.size() < MAX_NOTES_DEF)
      live_notes.insert(live_notes.size(), note);
    else if (action == ACT_NOTE_OFF && idx >= 0)
      live_notes.delete(idx);
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start   <= 1'b0;
      in_data <= in_t'(($bits(in_t))'($urandom));
      repeat ($urandom_range(1, 160)) @(negedge clk);
    end
  endtask

  task automatic wait_until_sent();
    start <= 1'b0;
    do @(posedge clk); while (entries_due != 0 || busy);
    @(negedge clk);
  endtask

  // Mostly list changes with random content; ignored messages do not count.
  task automatic send_random_round(input int wanted);
    int         counted;
    int         r;
    logic [3:0] chan;
    counted = 0;
    while (counted < wanted) begin
      r    = $urandom_range(99);
      chan = 4'($urandom);
      if (r < 50) begin
        send_msg(ACT_NOTE_ON, chan, free_note());
        counted++;
      end else if (r < 78 && live_notes.size() > 0) begin
        send_msg(ACT_NOTE_OFF, chan, live_notes[$urandom_range(live_notes.size() - 1)]);
        counted++;
      end else if (r < 85 && live_notes.size() > 0) begin
        send_msg(ACT_NOTE_ON, chan, live_notes[$urandom_range(live_notes.size() - 1)]);
        counted++;
      end else if (r < 92) begin
        send_msg(ACT_NOTE_OFF, chan, free_note());
        counted++;
      end else begin
        send_msg($urandom_range(1) ? ACT_OTHER : ACT_UNUSED, chan, 7'($urandom));
      end
    end
  endtask

  initial begin
    clk     = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    gap_pct = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, every action, each corner of the list
    send_msg(ACT_NOTE_OFF, 4'd3, 7'd5);      // off on an empty list
    send_msg(ACT_NOTE_ON, 4'd0, 7'd0);
    send_msg(ACT_NOTE_OFF, 4'd0, 7'd0);      // list goes empty, nothing sent
    send_msg(ACT_NOTE_ON, 4'd15, 7'd127);
    send_msg(ACT_NOTE_ON, 4'd0, 7'd0);
    send_msg(ACT_NOTE_ON, 4'd9, 7'd64);
    send_msg(ACT_NOTE_ON, 4'd3, 7'd127);     // duplicate note, other channel
    send_msg(ACT_OTHER, 4'd15, 7'd127);
    send_msg(ACT_UNUSED, 4'd0, 7'd64);
    send_msg(ACT_NOTE_OFF, 4'd15, 7'd99);    // off for a note not held
    send_msg(ACT_NOTE_OFF, 4'd7, 7'd0);      // middle entry
    send_msg(ACT_NOTE_OFF, 4'd9, 7'd64);     // last entry
    send_msg(ACT_NOTE_ON, 4'd10, 7'd85);
    send_msg(ACT_NOTE_ON, 4'd5, 7'd42);
    send_msg(ACT_NOTE_OFF, 4'd1, 7'd127);    // first entry
    send_msg(ACT_OTHER, 4'd0, 7'd0);
    wait_until_sent();

    gap_pct = 13;
    send_random_round(120);

    gap_pct = 60;
    send_random_round(60);
    // drain the list in random order
    while (live_notes.size() > 0)
      send_msg(ACT_NOTE_OFF, 4'($urandom),
               live_notes[$urandom_range(live_notes.size() - 1)]);
    send_random_round(60);

    gap_pct = 0;
    while (live_notes.size() < MAX_NOTES_DEF)
      send_msg(ACT_NOTE_ON, 4'($urandom), free_note());
    // full list: new notes drop, duplicates too
    repeat (3) send_msg(ACT_NOTE_ON, 4'($urandom), free_note());
    send_msg(ACT_NOTE_ON, 4'($urandom), live_notes[$urandom_range(MAX_NOTES_DEF - 1)]);
    wait_until_sent();
    send_random_round(30);

    wait_until_sent();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/anlt_pkg.sv
sv/anlt_ram.sv
sv/active_note_list_tracker_unit.sv
dv/note_list_checker.sv
dv/tb_active_note_list_tracker_unit.sv
